// ===== design/cnf_text_literal_parser_macros.svh =====
// Assertion macros shared by the CNF text parser modules.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef CNF_TEXT_LITERAL_PARSER_MACROS_SVH
`define CNF_TEXT_LITERAL_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CNF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CNF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cnf_pkg.sv =====
// Shared types, character codes and sizing for the CNF text parser.
// No dependencies.
package cnf_pkg;

    localparam int VAR_BITS_DEF  = 24;
    localparam int SIZE_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [1:0] {
        KIND_LIT = 2'd0,
        KIND_END = 2'd1,
        KIND_ERR = 2'd2,
        KIND_FIN = 2'd3
    } kind_t;

    typedef enum logic [6:0] {
        MODE_TOP    = 7'b0000001,
        MODE_SKIP   = 7'b0000010,
        MODE_EXPECT = 7'b0000100,
        MODE_SIGN   = 7'b0001000,
        MODE_DIGITS = 7'b0010000,
        MODE_ERROR  = 7'b0100000,
        MODE_DONE   = 7'b1000000
    } mode_t;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Width of one queue word: two result slots plus a two-result flag.
    function automatic int pair_bits(input int vb, input int sb);
        return 2 * (2 * vb + sb + 5) + 1;
    endfunction

endpackage

// ===== design/cnf_front.sv =====
// Front end of the CNF parser: classifies each byte, keeps the parse state
// and builds one queue word of up to two results. Depends on cnf_pkg and the macros header.
`include "cnf_text_literal_parser_macros.svh"

module cnf_front
    import cnf_pkg::*;
#(
    parameter int VAR_BITS  = VAR_BITS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     take,
    input  logic [7:0]                               in_byte,
    input  logic                                     end_of_input,
    output logic                                     pair_valid,
    output logic [pair_bits(VAR_BITS, SIZE_BITS)-1:0] pair_data
);

    typedef struct packed {
        kind_t                kind;
        logic [VAR_BITS-1:0]  var_index;
        logic                 negated;
        logic [SIZE_BITS-1:0] clause_size;
        logic [VAR_BITS:0]    var_count;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic two;
        res_t r1;
        res_t r0;
    } pair_t;

    mode_t                mode_reg, mode_next;
    logic [VAR_BITS-1:0]  num_reg, num_next;
    logic                 minus_reg, minus_next;
    logic [SIZE_BITS-1:0] lits_reg, lits_next;
    logic [VAR_BITS:0]    vars_reg, vars_next;

    logic                 is_digit;
    logic                 is_space;
    logic [VAR_BITS-1:0]  digit_val;
    logic [VAR_BITS+3:0]  prod;
    logic                 ovf;
    pair_t                pair;

    assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign is_space  = ((in_byte >= CH_TAB) && (in_byte <= CH_CR)) || (in_byte == CH_SPACE);
    assign digit_val = VAR_BITS'(in_byte - CH_ZERO);
    // times ten as shift-add, then the new digit
    assign prod = ({4'b0, num_reg} << 3) + ({4'b0, num_reg} << 1)
                + (VAR_BITS+4)'(in_byte - CH_ZERO);
    assign ovf  = |prod[VAR_BITS+3:VAR_BITS];

    always_comb
    begin
        logic  closed;
        logic  has_extra;
        mode_t m_after;
        res_t  first;
        res_t  extra;

        mode_next  = mode_reg;
        num_next   = num_reg;
        minus_next = minus_reg;
        lits_next  = lits_reg;
        vars_next  = vars_reg;
        closed     = 1'b0;
        has_extra  = 1'b0;
        m_after    = mode_reg;
        first      = '0;
        extra      = '0;

        if ((mode_reg != MODE_ERROR) && (mode_reg != MODE_DONE))
        begin
            // a number ends at end of input or at the first non-digit
            if ((mode_reg == MODE_DIGITS) && (end_of_input || !is_digit))
            begin
                closed = 1'b1;
                if (num_reg == '0)
                begin
                    first.kind        = KIND_END;
                    first.clause_size = lits_reg;
                    first.var_count   = vars_reg;
                    lits_next         = '0;
                    m_after           = MODE_TOP;
                end
                else
                begin
                    if (lits_reg != '1)
                        lits_next = lits_reg + 1'b1;
                    if (({1'b0, num_reg} + 1'b1) > vars_reg)
                        vars_next = {1'b0, num_reg} + 1'b1;
                    first.kind      = KIND_LIT;
                    first.var_index = num_reg;
                    first.negated   = minus_reg;
                    first.var_count = vars_next;
                    m_after         = MODE_EXPECT;
                end
                num_next   = '0;
                minus_next = 1'b0;
            end
            mode_next = m_after;

            if (end_of_input)
            begin
                has_extra = 1'b1;
                if ((m_after == MODE_TOP) || (m_after == MODE_SKIP))
                begin
                    mode_next  = MODE_DONE;
                    extra.kind = KIND_FIN;
                end
                else
                begin
                    mode_next  = MODE_ERROR;
                    extra.kind = KIND_ERR;
                end
            end
            else if (mode_reg == MODE_SKIP)
            begin
                if (in_byte == CH_LF)
                    mode_next = MODE_TOP;
            end
            else if (mode_reg == MODE_SIGN)
            begin
                if (is_digit)
                begin
                    num_next  = digit_val;
                    mode_next = MODE_DIGITS;
                end
                else
                begin
                    has_extra  = 1'b1;
                    extra.kind = KIND_ERR;
                    mode_next  = MODE_ERROR;
                end
            end
            else if ((mode_reg == MODE_DIGITS) && is_digit)
            begin
                if (ovf)
                begin
                    has_extra  = 1'b1;
                    extra.kind = KIND_ERR;
                    mode_next  = MODE_ERROR;
                end
                else
                    num_next = prod[VAR_BITS-1:0];
            end
            else if (!is_space)
            begin
                // handle the byte on its own, in the mode left after any close
                if ((m_after == MODE_TOP) && ((in_byte == CH_C) || (in_byte == CH_P)))
                    mode_next = MODE_SKIP;
                else if ((in_byte == CH_MINUS) || (in_byte == CH_PLUS))
                begin
                    minus_next = (in_byte == CH_MINUS);
                    mode_next  = MODE_SIGN;
                end
                else if (is_digit)
                begin
                    minus_next = 1'b0;
                    num_next   = digit_val;
                    mode_next  = MODE_DIGITS;
                end
                else
                begin
                    has_extra  = 1'b1;
                    extra.kind = KIND_ERR;
                    mode_next  = MODE_ERROR;
                end
            end
            extra.var_count = vars_next;
        end

        pair = '0;
        if (closed)
        begin
            pair.r0 = first;
            if (has_extra)
            begin
                pair.two     = 1'b1;
                pair.r1      = extra;
                pair.r1.last = 1'b1;
            end
            else
                pair.r0.last = 1'b1;
        end
        else
        begin
            pair.r0      = extra;
            pair.r0.last = 1'b1;
        end
        pair_valid = closed || has_extra;
    end

    assign pair_data = pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TOP;
            num_reg   <= '0;
            minus_reg <= 1'b0;
            lits_reg  <= '0;
            vars_reg  <= '0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            num_reg   <= num_next;
            minus_reg <= minus_next;
            lits_reg  <= lits_next;
            vars_reg  <= vars_next;
        end
    end

    `CNF_ASSERT_NEXT(a_error_sticky, mode_reg == MODE_ERROR, mode_reg == MODE_ERROR,
        "error mode left before reset")
    `CNF_ASSERT_NOW(a_two_after_close, pair_valid && pair.two,
        (pair.r0.kind == KIND_LIT) || (pair.r0.kind == KIND_END),
        "two results without a closed number first")
    `CNF_ASSERT_NOW(a_done_silent, mode_reg == MODE_DONE, !pair_valid,
        "result produced after input finished")

endmodule

// ===== design/cnf_back.sv =====
// Back end of the CNF parser: queue of result words, unpacked one result
// per pop. Depends on cnf_pkg and the macros header.
`include "cnf_text_literal_parser_macros.svh"

module cnf_back
    import cnf_pkg::*;
#(
    parameter int VAR_BITS  = VAR_BITS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     wr_en,
    input  logic [pair_bits(VAR_BITS, SIZE_BITS)-1:0] wr_data,
    output logic                                     full,
    output logic                                     empty,
    input  logic                                     pop,
    output logic [1:0]                               kind,
    output logic [VAR_BITS-1:0]                      var_index,
    output logic                                     negated,
    output logic [SIZE_BITS-1:0]                     clause_size,
    output logic [VAR_BITS:0]                        var_count,
    output logic                                     last
);

    localparam int PAIR_W = pair_bits(VAR_BITS, SIZE_BITS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        kind_t                kind;
        logic [VAR_BITS-1:0]  var_index;
        logic                 negated;
        logic [SIZE_BITS-1:0] clause_size;
        logic [VAR_BITS:0]    var_count;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic two;
        res_t r1;
        res_t r0;
    } pair_t;

    logic [PAIR_W-1:0] store [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              half_reg, half_next;

    pair_t head;
    res_t  cur;
    logic  pop_ok;
    logic  deq;

    assign head   = pair_t'(store[rd_ptr_reg]);
    assign cur    = half_reg ? head.r1 : head.r0;
    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_ok = pop && !empty;
    // release the word once its last result is taken
    assign deq    = pop_ok && (half_reg || !head.two);

    assign kind        = cur.kind;
    assign var_index   = cur.var_index;
    assign negated     = cur.negated;
    assign clause_size = cur.clause_size;
    assign var_count   = cur.var_count;
    assign last        = cur.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        half_next   = half_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            half_next   = 1'b0;
        end
        else if (pop_ok)
            half_next = 1'b1;
        count_next = count_reg + CNT_W'(wr_en) - CNT_W'(deq);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            half_reg   <= half_next;
        end
    end

    `CNF_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH),
        "queue count above depth")
    `CNF_ASSERT_NOW(a_half_needs_two, half_reg, !empty && head.two,
        "second slot shown for a single-result word")
    `CNF_ASSERT_NEXT(a_half_advance, pop_ok && !half_reg && head.two, half_reg,
        "second result skipped after first was taken")

endmodule

// ===== design/cnf_text_literal_parser.sv =====
// A result is written to the result queue when its byte is taken and is on the
// output ports once earlier results are popped. One byte per cycle while full is
// low; a byte that yields two results (a number closed and a new event) needs
// two pops, so a slow consumer fills the four-word result queue and full stalls the input.
// Reset: rst_n clears parse state and the queue at once; no clearing pass.
module cnf_text_literal_parser
    import cnf_pkg::*;
#(
    parameter int VAR_BITS  = VAR_BITS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_input,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           kind,
    output logic [VAR_BITS-1:0]  var_index,
    output logic                 negated,
    output logic [SIZE_BITS-1:0] clause_size,
    output logic [VAR_BITS:0]    var_count,
    output logic                 last
);

    localparam int PAIR_W = pair_bits(VAR_BITS, SIZE_BITS);

    logic              take;
    logic              pair_valid;
    logic [PAIR_W-1:0] pair_data;

    assign take = push && !full;

    cnf_front #(
        .VAR_BITS  (VAR_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .pair_valid   (pair_valid),
        .pair_data    (pair_data)
    );

    cnf_back #(
        .VAR_BITS  (VAR_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (take && pair_valid),
        .wr_data     (pair_data),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .var_index   (var_index),
        .negated     (negated),
        .clause_size (clause_size),
        .var_count   (var_count),
        .last        (last)
    );

endmodule
